/* rtl/rl_line_phasor_companion_step_macros.svh */
// ----------------------------------------------------------------------------
// RL line companion step - assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RL_LINE_PHASOR_COMPANION_STEP_MACROS_SVH
`define RL_LINE_PHASOR_COMPANION_STEP_MACROS_SVH

// same-cycle implication
`define RLPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RLPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rlpc_pkg.sv */
// ----------------------------------------------------------------------------
// RL line companion step - package
// Widths, register indexes, micro-op encoding, microcode and saturation.
// ----------------------------------------------------------------------------
package rlpc_pkg;

  localparam int VAL_W     = 32;
  localparam int OPD_W     = 33;
  localparam int PROD_W    = 66;
  localparam int ACC_W     = 68;
  localparam int STEP_W    = 5;
  localparam int CFG_IDX_W = 8;
  localparam int RES_W     = 31;
  localparam int FRAC_COEF = 24;
  localparam int FRAC_VAL  = 16;

  localparam logic [VAL_W-1:0] CORR_RESET = 32'h0100_0000;

  localparam logic signed [ACC_W-1:0] RND_COEF = ACC_W'(1) <<< (FRAC_COEF - 1);
  localparam logic signed [ACC_W-1:0] RND_VAL  = ACC_W'(1) <<< (FRAC_VAL - 1);

  // last sequencer step, pipeline drain included
  localparam logic [STEP_W-1:0] STEP_END_M0 = 5'd21;
  localparam logic [STEP_W-1:0] STEP_END_M1 = 5'd13;

  localparam logic MODE_SERIES = 1'b0;
  localparam logic MODE_SPLIT  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_MODE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COND_RE     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COND_IM     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIST_FAC_RE = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIST_FAC_IM = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CORR_RE     = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CORR_IM     = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SERIES_RES  = 8'd7;

  typedef enum logic [2:0] {
    A_GRE, A_GIM, A_FRE, A_FIM, A_CRE, A_CIM, A_RES
  } asel_t;

  typedef enum logic [2:0] {
    B_DRE, B_DIM, B_IRE, B_IIM, B_HRE, B_HIM, B_KRE, B_KIM
  } bsel_t;

  typedef enum logic [2:0] {
    BS_RND, BS_JRE, BS_JIM, BS_DXRE, BS_DXIM
  } base_t;

  typedef enum logic [2:0] {
    D_IRE, D_IIM, D_HRE, D_HIM, D_KRE, D_KIM, D_JRE, D_JIM
  } dest_t;

  typedef struct packed {
    logic  vld;
    asel_t a;
    bsel_t b;
    logic  neg;
    logic  first;
    logic  last;
    base_t base;
    dest_t dest;
  } uop_t;

  typedef struct packed {
    logic load_in;
    logic load_out;
    uop_t op;
  } cmd_t;

  typedef struct packed {
    logic mode;
  } stat_t;

  function automatic uop_t mk_uop(input asel_t a, input bsel_t b, input logic neg,
                                  input logic first, input logic last,
                                  input base_t base, input dest_t dest);
    uop_t u;
    u.vld   = 1'b1;
    u.a     = a;
    u.b     = b;
    u.neg   = neg;
    u.first = first;
    u.last  = last;
    u.base  = base;
    u.dest  = dest;
    return u;
  endfunction

  // at most one multiply per step; an accumulation opens on first and writes back on last
  function automatic uop_t uop_at(input logic mode, input logic [STEP_W-1:0] step);
    uop_t u;
    u = '0;
    case (step)
      5'd0: u = mk_uop(A_GRE, B_DRE, 1'b0, 1'b1, 1'b0, BS_JRE, D_IRE);
      5'd1: u = mk_uop(A_GIM, B_DIM, 1'b1, 1'b0, 1'b1, BS_JRE, D_IRE);
      5'd2: u = mk_uop(A_GIM, B_DRE, 1'b0, 1'b1, 1'b0, BS_JIM, D_IIM);
      5'd3: u = mk_uop(A_GRE, B_DIM, 1'b0, 1'b0, 1'b1, BS_JIM, D_IIM);
      default: begin
        if (mode == MODE_SPLIT) begin
          case (step)
            5'd4:  u = mk_uop(A_GRE, B_DRE, 1'b0, 1'b1, 1'b0, BS_RND, D_JRE);
            5'd5:  u = mk_uop(A_GIM, B_DIM, 1'b1, 1'b0, 1'b0, BS_RND, D_JRE);
            5'd6:  u = mk_uop(A_FRE, B_IRE, 1'b0, 1'b0, 1'b0, BS_RND, D_JRE);
            5'd7:  u = mk_uop(A_FIM, B_IIM, 1'b1, 1'b0, 1'b1, BS_RND, D_JRE);
            5'd8:  u = mk_uop(A_GIM, B_DRE, 1'b0, 1'b1, 1'b0, BS_RND, D_JIM);
            5'd9:  u = mk_uop(A_GRE, B_DIM, 1'b0, 1'b0, 1'b0, BS_RND, D_JIM);
            5'd10: u = mk_uop(A_FIM, B_IRE, 1'b0, 1'b0, 1'b0, BS_RND, D_JIM);
            5'd11: u = mk_uop(A_FRE, B_IIM, 1'b0, 1'b0, 1'b1, BS_RND, D_JIM);
            default: u = '0;
          endcase
        end else begin
          // bubbles wait for a write-back the next product needs
          case (step)
            5'd4:  u = mk_uop(A_RES, B_IRE, 1'b1, 1'b1, 1'b1, BS_DXRE, D_HRE);
            5'd6:  u = mk_uop(A_RES, B_IIM, 1'b1, 1'b1, 1'b1, BS_DXIM, D_HIM);
            5'd7:  u = mk_uop(A_FRE, B_IRE, 1'b0, 1'b1, 1'b0, BS_RND, D_KRE);
            5'd8:  u = mk_uop(A_FIM, B_IIM, 1'b1, 1'b0, 1'b0, BS_RND, D_KRE);
            5'd9:  u = mk_uop(A_GRE, B_HRE, 1'b0, 1'b0, 1'b0, BS_RND, D_KRE);
            5'd10: u = mk_uop(A_GIM, B_HIM, 1'b1, 1'b0, 1'b1, BS_RND, D_KRE);
            5'd11: u = mk_uop(A_FIM, B_IRE, 1'b0, 1'b1, 1'b0, BS_RND, D_KIM);
            5'd12: u = mk_uop(A_FRE, B_IIM, 1'b0, 1'b0, 1'b0, BS_RND, D_KIM);
            5'd13: u = mk_uop(A_GIM, B_HRE, 1'b0, 1'b0, 1'b0, BS_RND, D_KIM);
            5'd14: u = mk_uop(A_GRE, B_HIM, 1'b0, 1'b0, 1'b1, BS_RND, D_KIM);
            5'd15: u = mk_uop(A_CRE, B_KRE, 1'b0, 1'b1, 1'b0, BS_RND, D_JRE);
            5'd17: u = mk_uop(A_CIM, B_KIM, 1'b1, 1'b0, 1'b1, BS_RND, D_JRE);
            5'd18: u = mk_uop(A_CIM, B_KRE, 1'b0, 1'b1, 1'b0, BS_RND, D_JIM);
            5'd19: u = mk_uop(A_CRE, B_KIM, 1'b0, 1'b0, 1'b1, BS_RND, D_JIM);
            default: u = '0;
          endcase
        end
      end
    endcase
    return u;
  endfunction

  function automatic logic [VAL_W-1:0] sat_acc(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(32'h7FFF_FFFF);
    lo = ~hi;
    if (x > hi) return 32'h7FFF_FFFF;
    else if (x < lo) return 32'h8000_0000;
    else return x[VAL_W-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] sat_diff(input logic [VAL_W:0] d);
    if (d[VAL_W] != d[VAL_W-1]) return d[VAL_W] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else return d[VAL_W-1:0];
  endfunction

endpackage

/* rtl/rlpc_ctrl.sv */
// ----------------------------------------------------------------------------
// RL line companion step - controller
// Sequences the micro-ops of one step and owns the input and result handshakes.
// ----------------------------------------------------------------------------
`include "rl_line_phasor_companion_step_macros.svh"

module rlpc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  rlpc_pkg::stat_t stat,
  output rlpc_pkg::cmd_t  cmd
);
  import rlpc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} state_t;

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STEP_W-1:0]   end_step;

  assign end_step  = (stat.mode == MODE_SPLIT) ? STEP_END_M1 : STEP_END_M0;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_RUN;
          step_nxt    = '0;
        end
      end
      S_RUN: begin
        cmd.op   = uop_at(stat.mode, step_r);
        step_nxt = step_r + 5'd1;
        if (step_r == end_step) state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `RLPC_ASSERT_IMP(a_no_overwrite, cmd.load_out, !out_valid_r || out_ready, "result overwritten")
  `RLPC_ASSERT_NXT(a_start_run, in_valid && in_ready, state_r == S_RUN && step_r == '0, "bad start")
  `RLPC_ASSERT_NXT(a_hold_result, out_valid_r && !out_ready, out_valid_r, "result dropped")

endmodule

/* rtl/rlpc_dpath.sv */
// ----------------------------------------------------------------------------
// RL line companion step - datapath
// Coefficient registers, one 33x33 multiplier, accumulator, round/saturate
// write-back into the step registers, and the result register.
// ----------------------------------------------------------------------------
`include "rl_line_phasor_companion_step_macros.svh"

module rlpc_dpath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [rlpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rlpc_pkg::VAL_W-1:0]         cfg_data,
  input  logic signed [rlpc_pkg::VAL_W-1:0]  v_pos_re,
  input  logic signed [rlpc_pkg::VAL_W-1:0]  v_pos_im,
  input  logic signed [rlpc_pkg::VAL_W-1:0]  v_neg_re,
  input  logic signed [rlpc_pkg::VAL_W-1:0]  v_neg_im,
  input  rlpc_pkg::cmd_t                     cmd,
  output rlpc_pkg::stat_t                    stat,
  output logic signed [rlpc_pkg::VAL_W-1:0]  current_re,
  output logic signed [rlpc_pkg::VAL_W-1:0]  current_im,
  output logic signed [rlpc_pkg::VAL_W-1:0]  eq_current_re,
  output logic signed [rlpc_pkg::VAL_W-1:0]  eq_current_im
);
  import rlpc_pkg::*;

  // configuration
  logic                    mode_r;
  logic [VAL_W-1:0]        gre_r, gim_r, fre_r, fim_r, cre_r, cim_r;
  logic [RES_W-1:0]        res_r;

  // step registers
  logic [VAL_W:0]          dxre_r, dxim_r;
  logic [VAL_W-1:0]        ire_r, iim_r, hre_r, him_r, kre_r, kim_r, jre_r, jim_r;
  logic [VAL_W-1:0]        dre, dim;

  // multiply / accumulate pipeline
  logic signed [OPD_W-1:0]  a_op, b_op;
  logic signed [PROD_W-1:0] p_r;
  uop_t                     op1_r;
  logic signed [ACC_W-1:0]  acc_r, base_val, p_ext, addend;
  logic                     wb_r;
  dest_t                    wdest_r;
  logic [VAL_W-1:0]         wb_val;

  logic [VAL_W-1:0]         cur_re_r, cur_im_r, eq_re_r, eq_im_r;

  assign stat.mode = mode_r;
  assign dre = sat_diff(dxre_r);
  assign dim = sat_diff(dxim_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SERIES;
      gre_r  <= '0;
      gim_r  <= '0;
      fre_r  <= '0;
      fim_r  <= '0;
      cre_r  <= CORR_RESET;
      cim_r  <= '0;
      res_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LINE_MODE:   mode_r <= cfg_data[0];
        REG_COND_RE:     gre_r  <= cfg_data;
        REG_COND_IM:     gim_r  <= cfg_data;
        REG_HIST_FAC_RE: fre_r  <= cfg_data;
        REG_HIST_FAC_IM: fim_r  <= cfg_data;
        REG_CORR_RE:     cre_r  <= cfg_data;
        REG_CORR_IM:     cim_r  <= cfg_data;
        REG_SERIES_RES:  res_r  <= cfg_data[RES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // operand select runs off the issued op, not the registered one
    unique case (cmd.op.a)
      A_GRE:   a_op = {gre_r[VAL_W-1], gre_r};
      A_GIM:   a_op = {gim_r[VAL_W-1], gim_r};
      A_FRE:   a_op = {fre_r[VAL_W-1], fre_r};
      A_FIM:   a_op = {fim_r[VAL_W-1], fim_r};
      A_CRE:   a_op = {cre_r[VAL_W-1], cre_r};
      A_CIM:   a_op = {cim_r[VAL_W-1], cim_r};
      A_RES:   a_op = {2'b00, res_r};
      default: a_op = '0;
    endcase
    unique case (cmd.op.b)
      B_DRE: b_op = {dre[VAL_W-1], dre};
      B_DIM: b_op = {dim[VAL_W-1], dim};
      B_IRE: b_op = {ire_r[VAL_W-1], ire_r};
      B_IIM: b_op = {iim_r[VAL_W-1], iim_r};
      B_HRE: b_op = {hre_r[VAL_W-1], hre_r};
      B_HIM: b_op = {him_r[VAL_W-1], him_r};
      B_KRE: b_op = {kre_r[VAL_W-1], kre_r};
      B_KIM: b_op = {kim_r[VAL_W-1], kim_r};
      default: b_op = '0;
    endcase
  end

  always_comb begin
    unique case (op1_r.base)
      BS_RND:  base_val = RND_COEF;
      BS_JRE:  base_val = ({{(ACC_W-VAL_W){jre_r[VAL_W-1]}}, jre_r} <<< FRAC_COEF) + RND_COEF;
      BS_JIM:  base_val = ({{(ACC_W-VAL_W){jim_r[VAL_W-1]}}, jim_r} <<< FRAC_COEF) + RND_COEF;
      BS_DXRE: base_val = ({{(ACC_W-VAL_W-1){dxre_r[VAL_W]}}, dxre_r} <<< FRAC_VAL) + RND_VAL;
      BS_DXIM: base_val = ({{(ACC_W-VAL_W-1){dxim_r[VAL_W]}}, dxim_r} <<< FRAC_VAL) + RND_VAL;
      default: base_val = '0;
    endcase
    p_ext  = {{(ACC_W-PROD_W){p_r[PROD_W-1]}}, p_r};
    addend = op1_r.neg ? -p_ext : p_ext;
  end

  // voltage-scale results round at the value point, the rest at the coefficient point
  assign wb_val = (wdest_r == D_HRE || wdest_r == D_HIM) ? sat_acc(acc_r >>> FRAC_VAL)
                                                         : sat_acc(acc_r >>> FRAC_COEF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op1_r <= '0;
      wb_r  <= 1'b0;
      jre_r <= '0;
      jim_r <= '0;
    end else begin
      op1_r <= cmd.op;
      wb_r  <= op1_r.vld && op1_r.last;
      if (wb_r) begin
        unique case (wdest_r)
          D_JRE: jre_r <= wb_val;
          D_JIM: jim_r <= wb_val;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r <= a_op * b_op;
    if (op1_r.vld) acc_r <= (op1_r.first ? base_val : acc_r) + addend;
    wdest_r <= op1_r.dest;
    if (cmd.load_in) begin
      dxre_r <= {v_pos_re[VAL_W-1], v_pos_re} - {v_neg_re[VAL_W-1], v_neg_re};
      dxim_r <= {v_pos_im[VAL_W-1], v_pos_im} - {v_neg_im[VAL_W-1], v_neg_im};
    end
    if (wb_r) begin
      unique case (wdest_r)
        D_IRE: ire_r <= wb_val;
        D_IIM: iim_r <= wb_val;
        D_HRE: hre_r <= wb_val;
        D_HIM: him_r <= wb_val;
        D_KRE: kre_r <= wb_val;
        D_KIM: kim_r <= wb_val;
        default: ;
      endcase
    end
    if (cmd.load_out) begin
      cur_re_r <= ire_r;
      cur_im_r <= iim_r;
      eq_re_r  <= jre_r;
      eq_im_r  <= jim_r;
    end
  end

  assign current_re    = cur_re_r;
  assign current_im    = cur_im_r;
  assign eq_current_re = eq_re_r;
  assign eq_current_im = eq_im_r;

  `RLPC_ASSERT_IMP(a_load_quiet, cmd.load_in, !op1_r.vld && !wb_r, "input loaded mid-step")
  `RLPC_ASSERT_NXT(a_wb_follows, op1_r.vld && op1_r.last, wb_r, "write-back missed")
  `RLPC_ASSERT_IMP(a_out_quiet, cmd.load_out, !op1_r.vld && !wb_r, "result taken mid-step")

endmodule

/* rtl/rl_line_phasor_companion_step.sv */
// ----------------------------------------------------------------------------
// RL line companion step - top level
// Trapezoidal companion model of a series RL line in dynamic phasors:
// line current and next equivalent source current per solver step.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake               Payload
// in       sink       in_valid / in_ready     v_pos_re/im, v_neg_re/im (Q16.16)
// out      source     out_valid / out_ready   current_re/im, eq_current_re/im
// cfg      sink       cfg_valid / cfg_ready   cfg_index, cfg_data (always ready)
//
// The block takes one item at a time, sequenced through the single shared
// multiplier and its product, accumulator and write-back registers; in_ready
// stays low from the accepting edge while the item is in the sequence.
// in_ready returns the cycle after the result moves to the output register.
// A result waiting on out_ready stalls only the end of the following item.
// rst_n is synchronous; it clears state, pipeline and result valid.
// ----------------------------------------------------------------------------
module rl_line_phasor_companion_step (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [rlpc_pkg::VAL_W-1:0]  in_v_pos_re,
  input  logic signed [rlpc_pkg::VAL_W-1:0]  in_v_pos_im,
  input  logic signed [rlpc_pkg::VAL_W-1:0]  in_v_neg_re,
  input  logic signed [rlpc_pkg::VAL_W-1:0]  in_v_neg_im,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [rlpc_pkg::VAL_W-1:0]  out_current_re,
  output logic signed [rlpc_pkg::VAL_W-1:0]  out_current_im,
  output logic signed [rlpc_pkg::VAL_W-1:0]  out_eq_current_re,
  output logic signed [rlpc_pkg::VAL_W-1:0]  out_eq_current_im,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rlpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rlpc_pkg::VAL_W-1:0]         cfg_data
);
  import rlpc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  rlpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rlpc_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .v_pos_re      (in_v_pos_re),
    .v_pos_im      (in_v_pos_im),
    .v_neg_re      (in_v_neg_re),
    .v_neg_im      (in_v_neg_im),
    .cmd           (cmd),
    .stat          (stat),
    .current_re    (out_current_re),
    .current_im    (out_current_im),
    .eq_current_re (out_eq_current_re),
    .eq_current_im (out_eq_current_im)
  );

endmodule

/* bench/rl_line_phasor_companion_step_tb.sv */
// ----------------------------------------------------------------------------
// RL line companion step - testbench
// Drives node voltage beats through the valid/ready input channel and checks
// every line current and equivalent current against a bit-exact predictor of
// the trapezoidal companion update, over several coefficient sets and both
// line modes, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module rl_line_phasor_companion_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rlpc_pkg::*;

  localparam time CLK_PERIOD  = 10ns;
  localparam int  CYCLE_LIMIT = 1_000_000;
  localparam int  TAIL_CYCLES = 48;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'hA5;

  typedef logic signed [79:0] wide_t;
  typedef logic signed [31:0] word_t;

  localparam wide_t HALF_Q24 = 80'sd8388608;
  localparam wide_t HALF_Q16 = 80'sd32768;
  localparam wide_t WORD_MAX = 80'sd2147483647;
  localparam wide_t WORD_MIN = -80'sd2147483648;

  localparam word_t VOLT_MAX = 32'sh7FFF_FFFF;
  localparam word_t VOLT_MIN = 32'sh8000_0000;
  localparam word_t ONE_Q24  = 32'sh0100_0000;
  localparam word_t ONE_Q16  = 32'sh0001_0000;

  typedef enum {RX_ALWAYS, RX_PATTERN, RX_RANDOM} rx_style_t;

  typedef struct {
    word_t v_pos_re;
    word_t v_pos_im;
    word_t v_neg_re;
    word_t v_neg_im;
  } node_volts_t;

  typedef struct {
    word_t current_re;
    word_t current_im;
    word_t eq_current_re;
    word_t eq_current_im;
  } line_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [31:0]   in_v_pos_re = '0;
  logic signed [31:0]   in_v_pos_im = '0;
  logic signed [31:0]   in_v_neg_re = '0;
  logic signed [31:0]   in_v_neg_im = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [31:0]   out_current_re;
  logic signed [31:0]   out_current_im;
  logic signed [31:0]   out_eq_current_re;
  logic signed [31:0]   out_eq_current_im;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0]     cfg_data = '0;

  // predictor copy of the registers and the carried equivalent current
  logic  coef_mode = MODE_SERIES;
  word_t coef_g_re = '0;
  word_t coef_g_im = '0;
  word_t coef_f_re = '0;
  word_t coef_f_im = '0;
  word_t coef_c_re = CORR_RESET;
  word_t coef_c_im = '0;
  word_t coef_res  = '0;
  word_t eq_src_re = '0;
  word_t eq_src_im = '0;

  line_result_t pending_results[$];

  int        err_count = 0;
  int        cycle_count;
  bit        tx_gaps = 1'b1;
  int        tx_burst = 0;
  rx_style_t rx_style = RX_ALWAYS;
  logic [15:0] rx_mask = 16'hFFFF;
  int        hold_off_len = 0;
  int        hold_off_reqs = 0;

  rl_line_phasor_companion_step i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_v_pos_re       (in_v_pos_re),
    .in_v_pos_im       (in_v_pos_im),
    .in_v_neg_re       (in_v_neg_re),
    .in_v_neg_im       (in_v_neg_im),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_current_re    (out_current_re),
    .out_current_im    (out_current_im),
    .out_eq_current_re (out_eq_current_re),
    .out_eq_current_im (out_eq_current_im),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic wide_t prod(input word_t a, input word_t b);
    wide_t wa;
    wide_t wb;
    wa = a;
    wb = b;
    return wa * wb;
  endfunction

  function automatic word_t sat_word(input wide_t x);
    if (x > WORD_MAX) return VOLT_MAX;
    if (x < WORD_MIN) return VOLT_MIN;
    return x[31:0];
  endfunction

  // round half up from Q.40 products to Q16.16, then saturate
  function automatic word_t round_q24(input wide_t acc);
    return sat_word((acc + HALF_Q24) >>> 24);
  endfunction

  function automatic line_result_t predict_line_step(input node_volts_t v);
    line_result_t r;
    wide_t dre_x, dim_x, eq_re_x, eq_im_x;
    word_t dre, dim, ire, iim, hre, him, kre, kim, jre, jim;
    dre_x = v.v_pos_re - v.v_neg_re;
    dim_x = v.v_pos_im - v.v_neg_im;
    dre = sat_word(dre_x);
    dim = sat_word(dim_x);
    eq_re_x = eq_src_re;
    eq_im_x = eq_src_im;
    ire = round_q24(prod(coef_g_re, dre) - prod(coef_g_im, dim) + (eq_re_x <<< 24));
    iim = round_q24(prod(coef_g_im, dre) + prod(coef_g_re, dim) + (eq_im_x <<< 24));
    if (coef_mode == MODE_SERIES) begin
      // inductor voltage uses the unsaturated difference
      hre = sat_word(((dre_x <<< 16) - prod(coef_res, ire) + HALF_Q16) >>> 16);
      him = sat_word(((dim_x <<< 16) - prod(coef_res, iim) + HALF_Q16) >>> 16);
      kre = round_q24(prod(coef_f_re, ire) - prod(coef_f_im, iim)
                      + prod(coef_g_re, hre) - prod(coef_g_im, him));
      kim = round_q24(prod(coef_f_im, ire) + prod(coef_f_re, iim)
                      + prod(coef_g_im, hre) + prod(coef_g_re, him));
      jre = round_q24(prod(coef_c_re, kre) - prod(coef_c_im, kim));
      jim = round_q24(prod(coef_c_im, kre) + prod(coef_c_re, kim));
    end else begin
      hre = dre;
      him = dim;
      jre = round_q24(prod(coef_g_re, hre) - prod(coef_g_im, him)
                      + prod(coef_f_re, ire) - prod(coef_f_im, iim));
      jim = round_q24(prod(coef_g_im, hre) + prod(coef_g_re, him)
                      + prod(coef_f_im, ire) + prod(coef_f_re, iim));
    end
    eq_src_re = jre;
    eq_src_im = jim;
    r.current_re    = ire;
    r.current_im    = iim;
    r.eq_current_re = jre;
    r.eq_current_im = jim;
    return r;
  endfunction

  // ------------------------------------------------------------------ drivers

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_LINE_MODE:   coef_mode = data[0];
      REG_COND_RE:     coef_g_re = data;
      REG_COND_IM:     coef_g_im = data;
      REG_HIST_FAC_RE: coef_f_re = data;
      REG_HIST_FAC_IM: coef_f_im = data;
      REG_CORR_RE:     coef_c_re = data;
      REG_CORR_IM:     coef_c_im = data;
      REG_SERIES_RES:  coef_res  = {1'b0, data[RES_W-1:0]};
      default: ;
    endcase
  endtask

  task automatic end_cfg_writes();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_line_coefs(input logic mode, input word_t g_re, input word_t g_im,
                                 input word_t f_re, input word_t f_im,
                                 input word_t c_re, input word_t c_im, input word_t res);
    write_reg(REG_LINE_MODE, 32'(mode));
    write_reg(REG_COND_RE, g_re);
    write_reg(REG_COND_IM, g_im);
    write_reg(REG_HIST_FAC_RE, f_re);
    write_reg(REG_HIST_FAC_IM, f_im);
    write_reg(REG_CORR_RE, c_re);
    write_reg(REG_CORR_IM, c_im);
    write_reg(REG_SERIES_RES, res);
    end_cfg_writes();
  endtask

  task automatic send_step(input node_volts_t v);
    if (tx_gaps && tx_burst == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 30)) @(negedge clk);
      tx_burst = $urandom_range(1, 16);
    end
    if (tx_burst > 0) tx_burst--;
    @(negedge clk);
    in_valid    <= 1'b1;
    in_v_pos_re <= v.v_pos_re;
    in_v_pos_im <= v.v_pos_im;
    in_v_neg_re <= v.v_neg_re;
    in_v_neg_im <= v.v_neg_im;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_line_step(v));
  endtask

  task automatic send_volts(input word_t pr, input word_t pi, input word_t nr, input word_t ni);
    node_volts_t v;
    v.v_pos_re = pr;
    v.v_pos_im = pi;
    v.v_neg_re = nr;
    v.v_neg_im = ni;
    send_step(v);
  endtask

  // drop valid and hold until every result is back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // ------------------------------------------------------------- random items

  function automatic word_t rand_value();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return ($urandom_range(0, 1) != 0) ? VOLT_MAX : VOLT_MIN;
      default: return int'($urandom_range(0, 2097152)) - 1048576;
    endcase
  endfunction

  function automatic word_t rand_coef(input int span);
    case ($urandom_range(0, 19))
      0: return $urandom;
      1: return ($urandom_range(0, 1) != 0) ? VOLT_MAX : VOLT_MIN;
      default: return int'($urandom_range(0, 2 << span)) - (1 << span);
    endcase
  endfunction

  function automatic node_volts_t rand_volts();
    node_volts_t v;
    v.v_pos_re = rand_value();
    v.v_pos_im = rand_value();
    v.v_neg_re = rand_value();
    v.v_neg_im = rand_value();
    // ground one end now and then
    if ($urandom_range(0, 9) == 0) begin
      v.v_pos_re = '0;
      v.v_pos_im = '0;
    end
    if ($urandom_range(0, 9) == 0) begin
      v.v_neg_re = '0;
      v.v_neg_im = '0;
    end
    return v;
  endfunction

  task automatic load_random_config(input logic mode);
    logic [VAL_W-1:0] mode_word;
    logic [VAL_W-1:0] res_word;
    mode_word    = $urandom;
    mode_word[0] = mode;
    case ($urandom_range(0, 9))
      0: res_word = $urandom;
      1: res_word = '0;
      default: res_word = $urandom_range(0, 131072);
    endcase
    write_reg(REG_LINE_MODE, mode_word);
    write_reg(REG_COND_RE, rand_coef(23));
    write_reg(REG_COND_IM, rand_coef(23));
    write_reg(REG_HIST_FAC_RE, rand_coef(23));
    write_reg(REG_HIST_FAC_IM, rand_coef(23));
    write_reg(REG_CORR_RE, rand_coef(24));
    write_reg(REG_CORR_IM, rand_coef(24));
    write_reg(REG_SERIES_RES, res_word);
    if ($urandom_range(0, 2) == 0)
      write_reg(CFG_IDX_W'(REG_SERIES_RES + 1 + $urandom_range(0, 247)), $urandom);
    end_cfg_writes();
  endtask

  // -------------------------------------------------------------------- tests

  task automatic test_reset_defaults();
    send_volts(VOLT_MAX, VOLT_MIN, VOLT_MIN, VOLT_MAX);
    send_volts(ONE_Q16, -ONE_Q16, '0, '0);
  endtask

  task automatic test_field_extremes();
    wait_drained();
    load_line_coefs(MODE_SERIES, ONE_Q24, 32'sh0080_0000, 32'sh0080_0000, -32'sh0040_0000,
                    ONE_Q24, '0, ONE_Q16);
    send_volts('0, '0, '0, '0);
    send_volts(VOLT_MAX, VOLT_MAX, VOLT_MIN, VOLT_MIN);
    send_volts(VOLT_MIN, VOLT_MIN, VOLT_MAX, VOLT_MAX);
    send_volts(ONE_Q16, -ONE_Q16, '0, '0);
    send_volts('0, '0, 32'sh0002_0000, 32'sh0000_8000);
    send_volts(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA);
    wait_drained();
    write_reg(REG_LINE_MODE, 32'(MODE_SPLIT));
    end_cfg_writes();
    send_volts(VOLT_MAX, VOLT_MIN, VOLT_MIN, VOLT_MAX);
    send_volts('0, '0, '0, '0);
    // half-LSB products land exactly on the rounding boundary
    send_volts(32'sd1, -32'sd1, '0, '0);
    send_volts(-32'sd1, 32'sd1, 32'h5555_5555, 32'hAAAA_AAAA);
  endtask

  task automatic test_saturation();
    wait_drained();
    load_line_coefs(MODE_SERIES, VOLT_MAX, VOLT_MIN, VOLT_MIN, VOLT_MAX, VOLT_MIN, VOLT_MIN,
                    32'hFFFF_FFFF);
    send_volts(VOLT_MAX, VOLT_MIN, VOLT_MIN, VOLT_MAX);
    send_volts(ONE_Q24, '0, '0, '0);
    send_volts('0, '0, '0, '0);
    wait_drained();
    write_reg(REG_LINE_MODE, 32'(MODE_SPLIT));
    end_cfg_writes();
    send_volts(VOLT_MIN, VOLT_MAX, VOLT_MAX, VOLT_MIN);
    send_volts(ONE_Q16, ONE_Q16, '0, '0);
  endtask

  task automatic test_register_decode();
    wait_drained();
    load_line_coefs(MODE_SPLIT, 32'sh0020_0000, -32'sh0010_0000, 32'sh00C0_0000,
                    32'sh0008_0000, 32'sh00F0_0000, 32'sh0004_0000, '0);
    // only bit 0 of the mode and the low 31 bits of the resistance count
    write_reg(REG_LINE_MODE, 32'hFFFF_FFFE);
    write_reg(REG_SERIES_RES, 32'h8000_8000);
    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
    end_cfg_writes();
    send_volts(32'sh0003_0000, -32'sh0001_8000, 32'sh0000_4000, '0);
    send_volts(-32'sh0002_0000, 32'sh0005_0000, '0, 32'sh0001_0000);
  endtask

  task automatic test_mode_switch();
    wait_drained();
    load_line_coefs(MODE_SERIES, 32'sh0030_0000, 32'sh0018_0000, 32'sh00E0_0000,
                    -32'sh0010_0000, ONE_Q24, 32'sh0002_0000, 32'sh0000_2000);
    send_volts(32'sh0064_0000, 32'sh0010_0000, '0, '0);
    send_volts(32'sh0060_0000, 32'sh0020_0000, 32'sh0001_0000, '0);
    // state carries over into the other mode as is
    wait_drained();
    write_reg(REG_LINE_MODE, 32'(MODE_SPLIT));
    end_cfg_writes();
    send_volts(32'sh0058_0000, 32'sh0030_0000, '0, 32'sh0000_8000);
    send_volts(32'sh0050_0000, 32'sh0040_0000, '0, '0);
    wait_drained();
    write_reg(REG_LINE_MODE, 32'(MODE_SERIES));
    end_cfg_writes();
    send_volts(32'sh0048_0000, 32'sh0048_0000, 32'sh0002_0000, '0);
  endtask

  task automatic test_random_phases();
    int p;
    int n;
    for (p = 0; p < 12; p++) begin
      wait_drained();
      load_random_config((p % 2 == 0) ? MODE_SERIES : MODE_SPLIT);
      tx_gaps  = (p % 3 != 0);
      rx_style = rx_style_t'($urandom_range(0, 2));
      rx_mask  = 16'($urandom) | 16'h0001;
      for (n = 0; n < 140; n++) send_step(rand_volts());
    end
  endtask

  task automatic test_output_holdoff();
    int n;
    wait_drained();
    load_random_config(1'($urandom_range(0, 1)));
    tx_gaps  = 1'b0;
    rx_style = RX_ALWAYS;
    hold_off_len = 600;
    hold_off_reqs++;
    for (n = 0; n < 80; n++) send_step(rand_volts());
  endtask

  task automatic test_drain_pause();
    int b;
    int n;
    wait_drained();
    load_random_config(1'($urandom_range(0, 1)));
    tx_gaps  = 1'b1;
    rx_style = RX_RANDOM;
    for (b = 0; b < 5; b++) begin
      for (n = 0; n < 30; n++) send_step(rand_volts());
      wait_drained();
    end
  endtask

  // ------------------------------------------------------ receiver and checks

  initial begin : receiver
    int hold_left;
    int seen_reqs;
    int phase;
    hold_left = 0;
    seen_reqs = 0;
    phase     = 0;
    forever begin
      @(negedge clk);
      if (hold_off_reqs != seen_reqs) begin
        seen_reqs = hold_off_reqs;
        hold_left = hold_off_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_style)
          RX_ALWAYS:  out_ready <= 1'b1;
          RX_PATTERN: out_ready <= rx_mask[4'(phase)];
          default:    out_ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
      phase++;
    end
  end

  always @(posedge clk) begin
    line_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_current_re !== want.current_re) begin
          $error("current_re: expected %0d, got %0d", want.current_re, out_current_re);
          err_count++;
        end
        if (out_current_im !== want.current_im) begin
          $error("current_im: expected %0d, got %0d", want.current_im, out_current_im);
          err_count++;
        end
        if (out_eq_current_re !== want.eq_current_re) begin
          $error("eq_current_re: expected %0d, got %0d", want.eq_current_re,
                 out_eq_current_re);
          err_count++;
        end
        if (out_eq_current_im !== want.eq_current_im) begin
          $error("eq_current_im: expected %0d, got %0d", want.eq_current_im,
                 out_eq_current_im);
          err_count++;
        end
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("rl_line_phasor_companion_step_tb: errors");
    $finish;
  end

  // -------------------------------------------------------------------- main

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_field_extremes();
    test_saturation();
    test_register_decode();
    test_mode_switch();
    test_random_phases();
    test_output_holdoff();
    test_drain_pause();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() == 0 && err_count == 0)
      $display("rl_line_phasor_companion_step_tb: clean");
    else
      $display("rl_line_phasor_companion_step_tb: errors");
    $finish;
  end

endmodule

/* rl_line_phasor_companion_step.f */
+incdir+rtl
rtl/rlpc_pkg.sv
rtl/rlpc_ctrl.sv
rtl/rlpc_dpath.sv
rtl/rl_line_phasor_companion_step.sv
bench/rl_line_phasor_companion_step_tb.sv
